// ===== rtl/tpa_pkg.sv =====
`default_nettype none

package tpa_pkg;

   localparam int WORD_W      = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef enum logic [1:0] {
      TOPO_STRIP   = 2'd0,
      TOPO_FAN     = 2'd1,
      TOPO_LIST    = 2'd2,
      TOPO_INVALID = 2'd3
   } topo_type;

   // one queued command: up to three vertices, or a single error item
   typedef struct packed {
      logic              err;
      logic [1:0]        count;
      logic [WORD_W-1:0] w0;
      logic [WORD_W-1:0] w1;
      logic [WORD_W-1:0] w2;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/tpa_front.sv =====
`default_nettype none

module tpa_front #(
   parameter int VERTEX_WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [1:0]                  topology,
   input  wire logic [tpa_pkg::WORD_W-1:0]  vertex_word,
   input  wire logic                        last_in_primitive,
   output      logic                        cmd_push,
   output      tpa_pkg::cmd_type            cmd
);
   import tpa_pkg::*;

   localparam logic [63:0] VMASK64 =
      (VERTEX_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << VERTEX_WIDTH) - 64'd1);

   logic [WORD_W-1:0] first_ff, first_in;
   logic [WORD_W-1:0] older_ff, older_in;
   logic [WORD_W-1:0] newer_ff, newer_in;
   logic [1:0]        seen_ff, seen_in;
   logic              parity_ff, parity_in;
   logic [1:0]        phase_ff, phase_in;
   logic              halted_ff, halted_in;

   topo_type          topo;
   logic [WORD_W-1:0] v;
   logic              emit;
   logic              err;
   logic [1:0]        next_seen;
   logic [1:0]        next_phase;
   logic              live;

   always_comb begin
      topo       = topo_type'(topology);
      v          = vertex_word & VMASK64[WORD_W-1:0];
      emit       = 1'b0;
      err        = 1'b0;
      next_seen  = seen_ff;
      next_phase = phase_ff;
      cmd.err    = 1'b0;
      cmd.count  = 2'd3;
      cmd.w0     = older_ff;
      cmd.w1     = newer_ff;
      cmd.w2     = v;
      unique case (topo)
         TOPO_INVALID: begin
            err = 1'b1;
         end
         TOPO_LIST: begin
            next_phase = (phase_ff == 2'd2) ? 2'd0 : 2'(phase_ff + 2'd1);
            emit       = (phase_ff == 2'd2);
            err        = last_in_primitive && (next_phase != 2'd0);
         end
         TOPO_STRIP, TOPO_FAN: begin
            next_seen = (seen_ff < 2'd3) ? 2'(seen_ff + 2'd1) : 2'd3;
            emit      = (seen_ff >= 2'd2);
            err       = last_in_primitive && (next_seen < 2'd3);
            if (topo == TOPO_FAN) begin
               cmd.w0 = first_ff;
               cmd.w1 = newer_ff;
            end else if (parity_ff) begin
               cmd.w0 = newer_ff;
               cmd.w1 = older_ff;
            end
         end
      endcase
      if (err) begin
         cmd.err   = 1'b1;
         cmd.count = 2'd1;
         cmd.w0    = '0;
      end

      live     = accept && !halted_ff;
      cmd_push = live && (err || emit);

      first_in  = first_ff;
      older_in  = older_ff;
      newer_in  = newer_ff;
      seen_in   = seen_ff;
      parity_in = parity_ff;
      phase_in  = phase_ff;
      halted_in = halted_ff;
      if (live) begin
         if (err) begin
            halted_in = 1'b1;
         end else begin
            if (topo == TOPO_LIST) begin
               phase_in = next_phase;
               if (next_phase == 2'd1) begin
                  first_in = v;
               end
            end else begin
               seen_in   = next_seen;
               parity_in = !parity_ff;
               if (next_seen == 2'd1) begin
                  first_in = v;
               end
            end
            older_in = newer_ff;
            newer_in = v;
            if (last_in_primitive) begin
               seen_in   = 2'd0;
               parity_in = 1'b0;
               phase_in  = 2'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= '0;
         older_ff  <= '0;
         newer_ff  <= '0;
         seen_ff   <= 2'd0;
         parity_ff <= 1'b0;
         phase_ff  <= 2'd0;
         halted_ff <= 1'b0;
      end else begin
         first_ff  <= first_in;
         older_ff  <= older_in;
         newer_ff  <= newer_in;
         seen_ff   <= seen_in;
         parity_ff <= parity_in;
         phase_ff  <= phase_in;
         halted_ff <= halted_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tpa_queue.sv =====
`default_nettype none

module tpa_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire tpa_pkg::cmd_type wr_cmd,
   output      logic             full,
   input  wire logic             rd_en,
   output      tpa_pkg::cmd_type rd_cmd,
   output      logic             rd_valid
);
   import tpa_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = QPTR_W'(p + 1'b1);
      end
      return r;
   endfunction

   always_comb begin
      full      = (fill_ff == FILL_W'(QUEUE_DEPTH));
      rd_valid  = (fill_ff != '0);
      rd_cmd    = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_en ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = rd_en ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (wr_en && !rd_en) begin
         fill_in = FILL_W'(fill_ff + 1'b1);
      end else if (rd_en && !wr_en) begin
         fill_in = FILL_W'(fill_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tpa_back.sv =====
`default_nettype none

module tpa_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tpa_pkg::cmd_type            head,
   input  wire logic                        head_valid,
   output      logic                        head_pop,
   input  wire logic                        out_take,
   output      logic                        out_valid,
   output      logic [tpa_pkg::WORD_W-1:0]  out_vertex,
   output      logic                        out_error,
   output      logic                        out_end
);
   import tpa_pkg::*;

   logic              valid_ff, valid_in;
   logic [1:0]        idx_ff, idx_in;
   logic [WORD_W-1:0] vertex_ff, vertex_in;
   logic              error_ff, error_in;
   logic              end_ff, end_in;
   logic              load;
   logic              last_word;

   always_comb begin
      load      = head_valid && (!valid_ff || out_take);
      last_word = (idx_ff == 2'(head.count - 2'd1));
      head_pop  = load && last_word;
      unique case (idx_ff)
         2'd0:    vertex_in = head.w0;
         2'd1:    vertex_in = head.w1;
         default: vertex_in = head.w2;
      endcase
      error_in = head.err;
      end_in   = last_word;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = last_word ? 2'd0 : 2'(idx_ff + 2'd1);
      end else begin
         valid_in = valid_ff && !out_take;
         idx_in   = idx_ff;
      end
      out_valid  = valid_ff;
      out_vertex = vertex_ff;
      out_error  = error_ff;
      out_end    = end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vertex_ff <= vertex_in;
         error_ff  <= error_in;
         end_ff    <= end_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/triangle_primitive_assembler_unit.sv =====
// A vertex that emits passes through the command queue and then the output register to the rsp_ ports.
// Throughput: one vertex per cycle on the input side while full is low; one result per cycle out
// while pop is held, so a vertex that closes a triangle sends its three results one after another.
// The command queue between front and back holds two vertices' worth of results.
// Reset (synchronous, active high) clears the primitive state, the halt, the queue
// and the output valid bit; no clearing pass is needed.
`default_nettype none

module triangle_primitive_assembler_unit #(
   parameter int VERTEX_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output      logic        full,
   input  wire logic [1:0]  req_topology,
   input  wire logic [31:0] req_vertex_word,
   input  wire logic        req_last_in_primitive,
   output      logic        empty,
   input  wire logic        pop,
   output      logic [31:0] rsp_out_vertex,
   output      logic        rsp_error_flag,
   output      logic        rsp_end_of_run
);
   import tpa_pkg::*;

   logic    q_full;
   logic    accept;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type head;
   logic    head_valid;
   logic    head_pop;
   logic    out_valid;
   logic    out_take;

   assign full     = q_full;
   assign accept   = push && !q_full;
   assign empty    = !out_valid;
   assign out_take = pop && out_valid;

   tpa_front #(
      .VERTEX_WIDTH(VERTEX_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .topology          (req_topology),
      .vertex_word       (req_vertex_word),
      .last_in_primitive (req_last_in_primitive),
      .cmd_push          (cmd_push),
      .cmd               (cmd)
   );

   tpa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_push),
      .wr_cmd   (cmd),
      .full     (q_full),
      .rd_en    (head_pop),
      .rd_cmd   (head),
      .rd_valid (head_valid)
   );

   tpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .out_take   (out_take),
      .out_valid  (out_valid),
      .out_vertex (rsp_out_vertex),
      .out_error  (rsp_error_flag),
      .out_end    (rsp_end_of_run)
   );

endmodule

`default_nettype wire
